>>> sv/pulse_width_sensor_frame_decoder_defines.svh
// Assertion macros shared by the RTL of the pulse width sensor frame decoder.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pwsfd_pkg.sv
// Shared constants, status codes and the result type of the pulse width sensor
// frame decoder. No dependencies.
`default_nettype none

package pwsfd_pkg;

  localparam int PULSE_W = 16;
  localparam int CNT_W   = 7;
  localparam int FRAME_W = 48;
  localparam int ERR_W   = 3;
  localparam int IDX_W   = 2;

  localparam logic [CNT_W-1:0] FRAME_PULSES = 7'd96;
  localparam logic [CNT_W-1:0] LAST_MARK    = 7'd95;
  localparam logic [CNT_W-1:0] LAST_SPACE   = 7'd94;
  localparam logic [CNT_W-1:0] COUNT_SAT    = 7'd97;

  localparam logic [PULSE_W-1:0] MID_RESET   = 16'd1000;
  localparam logic [PULSE_W-1:0] SHORT_RESET = 16'd550;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [3:0] TYPE_NIB  = 4'h5;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_MID   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SHORT = 2'd1;

  // Status codes; the mark and space codes double as the first-error codes.
  localparam logic [ERR_W-1:0] ST_OK    = 3'd0;
  localparam logic [ERR_W-1:0] ST_COUNT = 3'd1;
  localparam logic [ERR_W-1:0] ST_MARK  = 3'd2;
  localparam logic [ERR_W-1:0] ST_SPACE = 3'd3;
  localparam logic [ERR_W-1:0] ST_SYNC  = 3'd4;
  localparam logic [ERR_W-1:0] ST_SUM   = 3'd5;

  typedef struct packed {
    logic [7:0]       temperature_raw;
    logic [7:0]       humidity;
    logic [1:0]       sensor_id;
    logic [ERR_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

>>> sv/pwsfd_frame_check.sv
// Frame verdict logic: checks count, recorded errors, sync/type and checksum
// and forms the result. Depends on pwsfd_pkg.
`default_nettype none

module pwsfd_frame_check (
  input  wire logic [pwsfd_pkg::CNT_W-1:0]   count,
  input  wire logic [pwsfd_pkg::FRAME_W-1:0] frame_bits,
  input  wire logic [pwsfd_pkg::ERR_W-1:0]   first_error,
  output pwsfd_pkg::result_t                 result
);
  import pwsfd_pkg::*;

  logic [7:0]       b0, b1, b2, b3, b4, b5;
  logic [7:0]       sum;
  logic [ERR_W-1:0] status;

  assign b0 = frame_bits[47:40];
  assign b1 = frame_bits[39:32];
  assign b2 = frame_bits[31:24];
  assign b3 = frame_bits[23:16];
  assign b4 = frame_bits[15:8];
  assign b5 = frame_bits[7:0];
  assign sum = b1 + b2 + b3 + b4;

  always_comb begin
    if (count != FRAME_PULSES) begin
      status = ST_COUNT;
    end else if (first_error != ST_OK) begin
      status = first_error;
    end else if (b0 != SYNC_BYTE || b1[7:4] != TYPE_NIB || b4 != SYNC_BYTE) begin
      status = ST_SYNC;
    end else if (sum != b5) begin
      status = ST_SUM;
    end else begin
      status = ST_OK;
    end
  end

  // Payload fields are zeroed on any failure.
  always_comb begin
    result.status = status;
    if (status == ST_OK) begin
      result.sensor_id       = b1[1:0];
      result.humidity        = b2;
      result.temperature_raw = b3;
    end else begin
      result.sensor_id       = 2'd0;
      result.humidity        = 8'd0;
      result.temperature_raw = 8'd0;
    end
  end

endmodule

`default_nettype wire

>>> sv/pulse_width_sensor_frame_decoder.sv
// Top level of the pulse width sensor frame decoder: pulse classification,
// train state, and a two-entry result buffer. Depends on pwsfd_pkg,
// pwsfd_frame_check and pulse_width_sensor_frame_decoder_defines.svh.
`default_nettype none

// The block takes one pulse length per item and accepts an item in every
// cycle while in_tready is high. Odd pulses 1 to 95 are marks: a mark longer
// than mid_threshold is a 0 bit, one no longer than short_threshold is a 1
// bit, and one in between is a bad mark. Even pulses 2 to 94 are spaces and
// must lie within [short_threshold, mid_threshold]. The 48 mark bits are
// shifted in MSB first to form six bytes. The item flagged with in_tlast
// closes the train: the block checks the pulse count (exactly 96), the first
// mark or space error, the sync bytes and type nibble, and the byte-sum
// checksum, and issues one result item; all other items issue none. The
// classification and the verdict happen in the cycle the item is accepted;
// the verdict is loaded into the result register, or, while a result waits
// there, into the skid register behind it, so the block keeps accepting
// pulses; in_tready falls only when both hold a result that has not been
// taken. The thresholds are written through the cfg port (index 0 mid,
// index 1 short, other indexes ignored); the user must write them only while
// the block is idle; the block does not enforce it. cfg_ready is always high.
module pulse_width_sensor_frame_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input item channel.
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [pwsfd_pkg::PULSE_W-1:0] in_tdata,   // [15:0] pulse_length
  input  wire logic                          in_tlast,   // last_pulse
  // Result item channel.
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // [2:0] status, [4:3] sensor_id, [12:5] humidity, [20:13] temperature_raw,
  // [23:21] zero
  output      logic [23:0]                   out_tdata,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [pwsfd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pwsfd_pkg::PULSE_W-1:0] cfg_data
);
  import pwsfd_pkg::*;

  `include "pulse_width_sensor_frame_decoder_defines.svh"

  // Threshold registers.
  logic [PULSE_W-1:0] mid_thr_r, short_thr_r;

  // Train state.
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;

  // Result buffer.
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  result_t verdict;

  logic in_acc, load, is_mark, is_space, too_long, too_short;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign load      = in_acc && in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_thr_r   <= MID_RESET;
      short_thr_r <= SHORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MID:   mid_thr_r   <= cfg_data;
        REG_SHORT: short_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position of this pulse in the train, saturating so that long trains fail.
  assign cnt_inc  = (cnt_r < COUNT_SAT) ? cnt_r + 7'd1 : cnt_r;
  assign is_mark  = cnt_inc[0] && (cnt_inc <= LAST_MARK);
  assign is_space = !cnt_inc[0] && (cnt_inc <= LAST_SPACE);
  assign too_long  = in_tdata > mid_thr_r;
  assign too_short = in_tdata < short_thr_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    err_nxt   = err_r;
    if (in_acc) begin
      if (in_tlast) begin
        cnt_nxt   = '0;
        frame_nxt = '0;
        err_nxt   = ST_OK;
      end else begin
        cnt_nxt = cnt_inc;
        if (is_mark) begin
          // A long mark is a 0, a short one a 1, the middle band is an error.
          frame_nxt = {frame_r[FRAME_W-2:0], !too_long && (in_tdata <= short_thr_r)};
          if (!too_long && in_tdata > short_thr_r && err_r == ST_OK) begin
            err_nxt = ST_MARK;
          end
        end else if (is_space) begin
          if ((too_long || too_short) && err_r == ST_OK) begin
            err_nxt = ST_SPACE;
          end
        end
      end
    end
  end

  // The closing pulse of a good train is pulse 96, a space that neither
  // shifts a bit nor is checked, so the current state is what gets judged.
  pwsfd_frame_check u_check (
    .count       (cnt_inc),
    .frame_bits  (frame_r),
    .first_error (err_r),
    .result      (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      frame_r <= '0;
      err_r <= ST_OK;
    end else begin
      cnt_r <= cnt_nxt;
      frame_r <= frame_nxt;
      err_r <= err_nxt;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= load;
    end else if (load) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || out_tready) begin
      if (load) begin
        out_data_r <= verdict;
      end
    end else if (load) begin
      skid_data_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  `PWSFD_ASSERT_NOW(a_fail_zero, out_valid_r && out_data_r.status != ST_OK,
    out_data_r.sensor_id == 2'd0 && out_data_r.humidity == 8'd0 &&
    out_data_r.temperature_raw == 8'd0, "failed result carries nonzero fields")
  `PWSFD_ASSERT_NEXT(a_last_clears, load,
    cnt_r == '0 && frame_r == '0 && err_r == ST_OK, "train state not cleared")
  `PWSFD_ASSERT_NEXT(a_last_delivers, load, out_valid_r, "closing pulse gave no result")
  `PWSFD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= COUNT_SAT, "pulse count past saturation")
  `PWSFD_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r,
    "skid entry without an output entry")

endmodule

`default_nettype wire
